[rtl/core/dsr_pkg.sv]
// shared types and constants for the decimal digit string rounder
`timescale 1ns / 1ps

package dsr_pkg;

    localparam int DIGIT_W        = 4;
    localparam int DIGITS         = 16;
    localparam int STRING_W       = DIGITS * DIGIT_W;
    localparam int COUNT_W        = 5;
    localparam int MAX_DIGITS_DEF = 16;

    localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(2);

    localparam logic [DIGIT_W-1:0] BCD_ZERO = 4'd0;
    localparam logic [DIGIT_W-1:0] BCD_ONE  = 4'd1;
    localparam logic [DIGIT_W-1:0] BCD_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_NINE = 4'd9;

    typedef enum logic
    {
        RM_NEAREST_EVEN = 1'b0,
        RM_HALF_UP      = 1'b1
    } round_mode_t;

    // per-digit findings of one lane
    typedef struct packed
    {
        logic                keep;
        logic                nine;
        logic                is_guard;
        logic                is_last;
        logic [DIGIT_W-1:0]  digit;
        logic [DIGIT_W-1:0]  inc;
    } lane_t;

endpackage

[rtl/core/dsr_in_if.sv]
// channel carrying one digit string to be rounded
`timescale 1ns / 1ps

interface dsr_in_if;
    import dsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STRING_W-1:0] digits_in;
    logic [COUNT_W-1:0]  digit_count;
    logic                sticky;
    logic                fixed_format;

    modport source
    (
        output valid,
        output digits_in,
        output digit_count,
        output sticky,
        output fixed_format,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  digits_in,
        input  digit_count,
        input  sticky,
        input  fixed_format,
        output ready
    );

endinterface

[rtl/core/dsr_out_if.sv]
// channel carrying one rounded digit string
`timescale 1ns / 1ps

interface dsr_out_if;
    import dsr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STRING_W-1:0] digits_out;
    logic [COUNT_W-1:0]  count_out;
    logic                overflow;

    modport source
    (
        output valid,
        output digits_out,
        output count_out,
        output overflow,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  digits_out,
        input  count_out,
        input  overflow,
        output ready
    );

endinterface

[rtl/core/dsr_lane.sv]
// one digit lane: classifies its digit against the kept count
`timescale 1ns / 1ps

module dsr_lane #(
    parameter int LANE = 0
) (
    input  logic [dsr_pkg::DIGIT_W-1:0] digit,
    input  logic [dsr_pkg::COUNT_W-1:0] keep_count,
    output dsr_pkg::lane_t              info
);
    import dsr_pkg::*;

    localparam logic [COUNT_W-1:0] IDX      = COUNT_W'(LANE);
    localparam logic [COUNT_W-1:0] IDX_NEXT = COUNT_W'(LANE + 1);

    always_comb
    begin
        info.keep     = IDX < keep_count;
        info.nine     = digit >= BCD_NINE;
        info.is_guard = IDX == keep_count;
        info.is_last  = IDX_NEXT == keep_count;
        info.digit    = digit;
        info.inc      = digit + BCD_ONE;
    end

endmodule

[rtl/core/dsr_merge.sv]
// merge stage: round decision, carry chain across lanes, result assembly
`timescale 1ns / 1ps

module dsr_merge (
    input  dsr_pkg::lane_t               lanes [dsr_pkg::DIGITS],
    input  logic [dsr_pkg::COUNT_W-1:0]  keep_count,
    input  logic                         sticky,
    input  logic                         fixed_format,
    input  dsr_pkg::round_mode_t         mode,
    output logic [dsr_pkg::STRING_W-1:0] digits_out,
    output logic [dsr_pkg::COUNT_W-1:0]  count_out,
    output logic                         overflow
);
    import dsr_pkg::*;

    logic [DIGIT_W-1:0] guard;
    logic [DIGIT_W-1:0] last;
    logic               round_up;
    logic               carry;
    logic [DIGITS-1:0]  carry_in;

    always_comb
    begin
        guard = BCD_ZERO;
        last  = BCD_ZERO;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (lanes[i].is_guard)
            begin
                guard = guard | lanes[i].digit;
            end
            if (lanes[i].is_last)
            begin
                last = last | lanes[i].digit;
            end
        end
    end

    always_comb
    begin
        unique case (mode)
            RM_HALF_UP:
            begin
                round_up = guard >= BCD_FIVE;
            end
            default:
            begin
                round_up = (guard > BCD_FIVE) ||
                           ((guard == BCD_FIVE) && (sticky || last[0]));
            end
        endcase
    end

    // carry ripples from the last kept digit toward the first
    always_comb
    begin
        carry = round_up;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            carry_in[i] = carry;
            if (lanes[i].keep)
            begin
                carry = carry & lanes[i].nine;
            end
        end
    end

    assign overflow  = carry;
    assign count_out = keep_count + COUNT_W'(carry & fixed_format);

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (carry)
            begin
                digits_out[STRING_W-1-DIGIT_W*i -: DIGIT_W] = (i == 0) ? BCD_ONE : BCD_ZERO;
            end
            else if (!lanes[i].keep)
            begin
                digits_out[STRING_W-1-DIGIT_W*i -: DIGIT_W] = BCD_ZERO;
            end
            else if (carry_in[i])
            begin
                digits_out[STRING_W-1-DIGIT_W*i -: DIGIT_W] =
                    lanes[i].nine ? BCD_ZERO : lanes[i].inc;
            end
            else
            begin
                digits_out[STRING_W-1-DIGIT_W*i -: DIGIT_W] = lanes[i].digit;
            end
        end
    end

endmodule

[rtl/core/decimal_digit_string_rounder.sv]
// top level of the decimal digit string rounder
`timescale 1ns / 1ps

// Rounds a packed BCD string of 2 to MAX_DIGITS digits (first digit in the top
// nibble, guard digit last) to one digit fewer, by ties-to-even or half-up as
// mode_reg selects; the user must write it through cfg_wr_en / cfg_wr_data only
// while idle, which the block does not enforce. One item is accepted every
// cycle unless a held result stalls the output; one register stage holds the
// per-digit lane findings, the second holds the merged result after the carry
// chain across the lanes. digit_count outside 2..MAX_DIGITS is clamped. A carry
// out of the first digit yields 1 followed by zeros and sets overflow; with
// fixed_format a zero digit is appended. Nibbles past count_out are always zero.
module decimal_digit_string_rounder #(
    parameter int MAX_DIGITS = dsr_pkg::MAX_DIGITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    dsr_in_if.sink    digit_ch,
    dsr_out_if.source round_ch
);
    import dsr_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_DIGITS);

    round_mode_t        mode_reg;
    logic [COUNT_W-1:0] clamped_count;
    logic [COUNT_W-1:0] keep_count;
    lane_t              lane_info [DIGITS];

    logic               s1_valid_reg;
    lane_t              s1_lanes_reg [DIGITS];
    logic [COUNT_W-1:0] s1_keep_reg;
    logic               s1_sticky_reg;
    logic               s1_fixed_reg;

    logic [STRING_W-1:0] merge_digits;
    logic [COUNT_W-1:0]  merge_count;
    logic                merge_overflow;

    logic                out_valid_reg;
    logic [STRING_W-1:0] out_digits_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_overflow_reg;

    logic advance;
    logic s1_load;

    always_comb
    begin
        priority if (digit_ch.digit_count < MIN_COUNT)
        begin
            clamped_count = MIN_COUNT;
        end
        else if (digit_ch.digit_count > MAX_COUNT)
        begin
            clamped_count = MAX_COUNT;
        end
        else
        begin
            clamped_count = digit_ch.digit_count;
        end
    end

    assign keep_count = clamped_count - COUNT_W'(1);

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_lane
        if (i < MAX_DIGITS)
        begin : g_used
            dsr_lane #(
                .LANE(i)
            ) u_lane (
                .digit     (digit_ch.digits_in[STRING_W-1-DIGIT_W*i -: DIGIT_W]),
                .keep_count(keep_count),
                .info      (lane_info[i])
            );
        end
        else
        begin : g_unused
            assign lane_info[i] = '0;
        end
    end

    dsr_merge u_merge (
        .lanes       (s1_lanes_reg),
        .keep_count  (s1_keep_reg),
        .sticky      (s1_sticky_reg),
        .fixed_format(s1_fixed_reg),
        .mode        (mode_reg),
        .digits_out  (merge_digits),
        .count_out   (merge_count),
        .overflow    (merge_overflow)
    );

    // output stage moves unless a result is held; lane stage fills any bubble
    assign advance        = !out_valid_reg || round_ch.ready;
    assign s1_load        = advance || !s1_valid_reg;
    assign digit_ch.ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= RM_NEAREST_EVEN;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= round_mode_t'(cfg_wr_data);
            end
            if (s1_load)
            begin
                s1_valid_reg <= digit_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_lanes_reg  <= lane_info;
            s1_keep_reg   <= keep_count;
            s1_sticky_reg <= digit_ch.sticky;
            s1_fixed_reg  <= digit_ch.fixed_format;
        end
        if (advance)
        begin
            out_digits_reg   <= merge_digits;
            out_count_reg    <= merge_count;
            out_overflow_reg <= merge_overflow;
        end
    end

    assign round_ch.valid      = out_valid_reg;
    assign round_ch.digits_out = out_digits_reg;
    assign round_ch.count_out  = out_count_reg;
    assign round_ch.overflow   = out_overflow_reg;

endmodule
